@@ hdl/srtf_pkg.sv @@
// Shared types, widths and constants for the SRTF scheduler unit.
// Used by srtf_ctrl, srtf_dp and srtf_preemptive_scheduler_unit; depends on nothing.
package srtf_pkg;

  // Process table size and derived index and count widths.
  localparam int unsigned MAX_PROCS = 64;
  localparam int unsigned IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_PROCS + 1);

  // Field widths.
  localparam int unsigned ID_W   = 16;
  localparam int unsigned TIME_W = 24;
  localparam int unsigned SUM_W  = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  // Stream word layouts.
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 176;
  localparam int unsigned M_TUSER_W = 3;

  // Input word kinds carried on the slave tuser bit.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Bit positions of the flags on the master tuser.
  localparam int unsigned USR_REJECTED = 0;
  localparam int unsigned USR_RAN      = 1;
  localparam int unsigned USR_FINISHED = 2;

  // One process table entry.
  typedef struct packed {
    logic [ID_W-1:0] ident;
    logic [15:0]     arrival;
    logic [15:0]     burst;
    logic [15:0]     remaining;
  } entry_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_COMMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan_en;
    logic calc_en;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/srtf_preemptive_scheduler_unit.sv @@
// Top level of the shortest-remaining-time-first scheduler unit.
// Instantiates srtf_ctrl and srtf_dp; depends on srtf_pkg.
// A load word goes from capture straight to commit; a tick word first scans the table,
// one entry per cycle through the single read port of the table memory, then passes the
// calc state before commit. The result word is registered at commit.
// One word in work at a time; the next word is taken once the result is registered, and
// commit waits while an earlier result word still waits for m_axis_tready.
// Reset clears counters, time, totals and handshake state; table entries are not cleared.
module srtf_preemptive_scheduler_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] proc_id, [31:16] arrival_time, [47:32] burst_time
  input  logic [srtf_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [0] mode
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] ran_id, [31:16] finished_id, [55:32] completion_time, [79:56] turnaround,
  // [103:80] waiting, [104] all_done, [136:105] total_wait,
  // [168:137] total_turnaround, [175:169] zero
  output logic [srtf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] load_rejected, [1] ran_valid, [2] finished
  output logic [srtf_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import srtf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  srtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_mode_i   (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, scan and result datapath.
  srtf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .s_mode_i   (s_axis_tuser),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

  // A commit never overwrites a word that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("commit while output word is held");

  // Every commit presents a word in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_axis_tvalid)
    else $error("commit did not produce an output word");

  // A finished process must also have run in that tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[USR_FINISHED]) |-> m_axis_tuser[USR_RAN])
    else $error("finished without ran_valid");

  // A rejected load never reports a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[USR_REJECTED]) |-> !m_axis_tuser[USR_RAN])
    else $error("rejected load reports a run");

endmodule

@@ hdl/srtf_ctrl.sv @@
// Sequencing state machine of the SRTF scheduler unit.
// Depends on srtf_pkg; drives the command struct of srtf_dp.
module srtf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  input  logic           s_mode_i,
  output logic           s_tready_o,
  input  srtf_pkg::sts_t sts_i,
  output srtf_pkg::cmd_t cmd_o
);
  import srtf_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (s_mode_i == MODE_TICK) ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc_en = 1'b1;
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/srtf_dp.sv @@
// Datapath of the SRTF scheduler unit: process table memory, minimum scan,
// timing arithmetic, running totals and the output word register. Depends on srtf_pkg.
module srtf_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [srtf_pkg::S_TDATA_W-1:0]      s_tdata_i,
  input  logic                                s_mode_i,
  input  srtf_pkg::cmd_t                      cmd_i,
  output srtf_pkg::sts_t                      sts_o,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [srtf_pkg::M_TDATA_W-1:0]      m_tdata_o,
  output logic [srtf_pkg::M_TUSER_W-1:0]      m_tuser_o
);
  import srtf_pkg::*;

  // Captured input word.
  logic            mode_q;
  logic [ID_W-1:0] in_id_q;
  logic [15:0]     in_at_q;
  logic [15:0]     in_bt_q;

  // Architectural state.
  logic [CNT_W-1:0]  loaded_q, loaded_d;
  logic [CNT_W-1:0]  done_q, done_d;
  logic [TIME_W-1:0] time_q, time_next;
  logic [SUM_W-1:0]  wsum_q, wsum_d;
  logic [SUM_W-1:0]  tsum_q, tsum_d;

  // Scan state.
  logic [CNT_W-1:0] rd_cnt_q;
  logic             pend_q;
  logic [IDX_W-1:0] pend_idx_q;
  logic             have_q;
  logic [IDX_W-1:0] best_idx_q;
  entry_t           best_q;
  entry_t           rd_data_q;
  logic             rd_en;
  logic             better;

  // Timing results of the chosen entry.
  logic [TIME_W-1:0] tat_q, wt_q, tat_calc, wt_calc;

  // Table write port.
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  // Commit decode.
  logic             full, rejected, ran, fin;
  logic [SUM_W:0]   wsum_wide, tsum_wide;

  // Output word register.
  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic [M_TUSER_W-1:0] m_user_q, m_user_d;

  entry_t mem_q [MAX_PROCS];

  // Process table: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_cnt_q[IDX_W-1:0]];
    end
  end

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= s_mode_i;
      in_id_q <= s_tdata_i[15:0];
      in_at_q <= s_tdata_i[31:16];
      in_bt_q <= s_tdata_i[47:32];
    end
  end

  // The scan reads one entry a cycle and compares it in the cycle after the read.
  assign rd_en  = cmd_i.scan_en && (rd_cnt_q != loaded_q);
  assign better = pend_q && ({{(TIME_W-16){1'b0}}, rd_data_q.arrival} <= time_q) &&
                  (rd_data_q.remaining != 16'd0) &&
                  (!have_q || (rd_data_q.remaining < best_q.remaining));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
      pend_q   <= 1'b0;
      have_q   <= 1'b0;
    end else if (cmd_i.capture) begin
      rd_cnt_q <= '0;
      pend_q   <= 1'b0;
      have_q   <= 1'b0;
    end else if (cmd_i.scan_en) begin
      pend_q <= rd_en;
      if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + CNT_W'(1);
      end
      if (better) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      pend_idx_q <= rd_cnt_q[IDX_W-1:0];
    end
    if (cmd_i.scan_en && better) begin
      best_q     <= rd_data_q;
      best_idx_q <= pend_idx_q;
    end
  end

  // Time after this tick, saturating.
  assign time_next = (time_q == TIME_MAX) ? time_q : time_q + TIME_W'(1);

  // Turnaround and waiting of the chosen entry, clamped at zero.
  always_comb begin
    tat_calc = (time_next >= TIME_W'(best_q.arrival)) ?
               time_next - TIME_W'(best_q.arrival) : '0;
    wt_calc  = (tat_calc >= TIME_W'(best_q.burst)) ?
               tat_calc - TIME_W'(best_q.burst) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_en) begin
      tat_q <= tat_calc;
      wt_q  <= wt_calc;
    end
  end

  // Commit: table write, counters, totals and the result word.
  always_comb begin
    full     = (loaded_q == CNT_W'(MAX_PROCS));
    rejected = (mode_q == MODE_LOAD) && (full || (in_bt_q == 16'd0));
    ran      = (mode_q == MODE_TICK) && have_q;
    fin      = ran && (best_q.remaining == 16'd1);

    wr_en   = 1'b0;
    wr_addr = best_idx_q;
    wr_data = best_q;
    wr_data.remaining = best_q.remaining - 16'd1;
    if (cmd_i.commit) begin
      if ((mode_q == MODE_LOAD) && !rejected) begin
        wr_en   = 1'b1;
        wr_addr = loaded_q[IDX_W-1:0];
        wr_data = '{ident: in_id_q, arrival: in_at_q, burst: in_bt_q,
                    remaining: in_bt_q};
      end else if (ran) begin
        wr_en = 1'b1;
      end
    end

    loaded_d = loaded_q;
    if ((mode_q == MODE_LOAD) && !rejected) begin
      loaded_d = loaded_q + CNT_W'(1);
    end
    done_d    = fin ? done_q + CNT_W'(1) : done_q;
    wsum_wide = {1'b0, wsum_q} + {{(SUM_W-TIME_W+1){1'b0}}, wt_q};
    tsum_wide = {1'b0, tsum_q} + {{(SUM_W-TIME_W+1){1'b0}}, tat_q};
    wsum_d    = wsum_q;
    tsum_d    = tsum_q;
    if (fin) begin
      wsum_d = wsum_wide[SUM_W] ? SUM_MAX : wsum_wide[SUM_W-1:0];
      tsum_d = tsum_wide[SUM_W] ? SUM_MAX : tsum_wide[SUM_W-1:0];
    end

    m_user_d = '0;
    m_user_d[USR_REJECTED] = rejected;
    m_user_d[USR_RAN]      = ran;
    m_user_d[USR_FINISHED] = fin;

    m_data_d = '0;
    m_data_d[15:0]    = ran ? best_q.ident : '0;
    m_data_d[31:16]   = fin ? best_q.ident : '0;
    m_data_d[55:32]   = fin ? time_next : '0;
    m_data_d[79:56]   = fin ? tat_q : '0;
    m_data_d[103:80]  = fin ? wt_q : '0;
    m_data_d[104]     = (done_d == loaded_d);
    m_data_d[136:105] = wsum_d;
    m_data_d[168:137] = tsum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      done_q   <= '0;
      time_q   <= '0;
      wsum_q   <= '0;
      tsum_q   <= '0;
    end else if (cmd_i.commit) begin
      loaded_q <= loaded_d;
      done_q   <= done_d;
      wsum_q   <= wsum_d;
      tsum_q   <= tsum_d;
      if (mode_q == MODE_TICK) begin
        time_q <= time_next;
      end
    end
  end

  // Output word register; a waiting word does not stop the next capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      m_data_q <= m_data_d;
      m_user_q <= m_user_d;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

  // Status back to the controller.
  assign sts_o.scan_done = (rd_cnt_q == loaded_q) && !pend_q;
  assign sts_o.out_free  = !m_valid_q || m_tready_i;

endmodule

@@ test/srtf_sched_checker.sv @@
// Scoreboard for the SRTF scheduler unit: predicts each result word from the accepted
// input words and compares it field by field with what the unit sends out.
// Depends on srtf_pkg for stream widths, word kinds and flag positions.
module srtf_sched_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // [15:0] proc_id, [31:16] arrival_time, [47:32] burst_time
  input  logic [srtf_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [0] mode
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] ran_id, [31:16] finished_id, [55:32] completion_time, [79:56] turnaround,
  // [103:80] waiting, [104] all_done, [136:105] total_wait,
  // [168:137] total_turnaround, [175:169] zero
  input  logic [srtf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] load_rejected, [1] ran_valid, [2] finished
  input  logic [srtf_pkg::M_TUSER_W-1:0] m_axis_tuser,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    waiting_count_o,
  output int unsigned                    finish_count_o,
  output int unsigned                    reject_count_o,
  output int unsigned                    idle_tick_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import srtf_pkg::*;

  // One result word of the scheduler, unpacked.
  typedef struct packed {
    logic              rejected;
    logic              ran;
    logic [ID_W-1:0]   ran_id;
    logic              finished;
    logic [ID_W-1:0]   finished_id;
    logic [TIME_W-1:0] done_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
    logic [SUM_W-1:0]  wait_total;
    logic [SUM_W-1:0]  tat_total;
    logic [6:0]        pad;
  } sched_word_t;

  // Shadow copy of the process table and the scheduler counters.
  logic [ID_W-1:0]   tbl_ident  [MAX_PROCS];
  logic [15:0]       tbl_arrive [MAX_PROCS];
  logic [15:0]       tbl_burst  [MAX_PROCS];
  logic [15:0]       tbl_left   [MAX_PROCS];
  int unsigned       n_loaded;
  int unsigned       n_done;
  logic [TIME_W-1:0] now_t;
  logic [SUM_W-1:0]  wait_sum;
  logic [SUM_W-1:0]  tat_sum;
  int unsigned       words_seen;

  // Predicted result words, oldest first.
  sched_word_t outcome_q[$];

  function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + b;
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // Apply one input word to the shadow state and return the word the unit should send.
  function automatic sched_word_t advance_schedule(input logic kind,
                                                   input logic [15:0] id,
                                                   input logic [15:0] arr,
                                                   input logic [15:0] bt);
    sched_word_t r;
    logic        found;
    int unsigned pick;
    int unsigned i;
    logic [15:0] best;
    r     = '0;
    found = 1'b0;
    pick  = 0;
    best  = '0;
    if (kind == MODE_LOAD) begin
      if (n_loaded >= MAX_PROCS || bt == 16'd0) begin
        r.rejected = 1'b1;
      end else begin
        tbl_ident[n_loaded]  = id;
        tbl_arrive[n_loaded] = arr;
        tbl_burst[n_loaded]  = bt;
        tbl_left[n_loaded]   = bt;
        n_loaded++;
      end
    end else begin
      // Shortest remaining work among arrived entries; the lowest index wins a tie.
      for (i = 0; i < n_loaded; i++) begin
        if (tbl_arrive[i] <= now_t && tbl_left[i] != 16'd0 &&
            (!found || tbl_left[i] < best)) begin
          found = 1'b1;
          best  = tbl_left[i];
          pick  = i;
        end
      end
      if (now_t != TIME_MAX) now_t++;
      if (found) begin
        r.ran    = 1'b1;
        r.ran_id = tbl_ident[pick];
        tbl_left[pick]--;
        if (tbl_left[pick] == 16'd0) begin
          r.finished    = 1'b1;
          r.finished_id = tbl_ident[pick];
          r.done_time   = now_t;
          r.turnaround  = (now_t >= tbl_arrive[pick]) ? now_t - tbl_arrive[pick] : '0;
          r.waiting     = (r.turnaround >= tbl_burst[pick]) ?
                          r.turnaround - tbl_burst[pick] : '0;
          wait_sum      = add_clamped(wait_sum, r.waiting);
          tat_sum       = add_clamped(tat_sum, r.turnaround);
          n_done++;
        end
      end
    end
    r.all_done   = (n_done == n_loaded);
    r.wait_total = wait_sum;
    r.tat_total  = tat_sum;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10)
        $display("%0t: word %0d field %s: expected 0x%0h, got 0x%0h",
                 $time, words_seen, name, want, got);
    end
  endtask

  // Predict on accepted input words, compare on accepted output words.
  always @(posedge clk_i or negedge rst_ni) begin
    sched_word_t want;
    sched_word_t got;
    if (!rst_ni) begin
      n_loaded          = 0;
      n_done            = 0;
      now_t             = '0;
      wait_sum          = '0;
      tat_sum           = '0;
      words_seen        = 0;
      outcome_q.delete();
      mismatch_count_o  = 0;
      waiting_count_o   = 0;
      finish_count_o    = 0;
      reject_count_o    = 0;
      idle_tick_count_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = advance_schedule(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                                s_axis_tdata[47:32]);
        if (want.finished) finish_count_o++;
        if (want.rejected) reject_count_o++;
        if (s_axis_tuser == MODE_TICK && !want.ran) idle_tick_count_o++;
        outcome_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: result word with nothing expected, tdata 0x%0h tuser 0x%0h",
                     $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want            = outcome_q.pop_front();
          got.rejected    = m_axis_tuser[USR_REJECTED];
          got.ran         = m_axis_tuser[USR_RAN];
          got.finished    = m_axis_tuser[USR_FINISHED];
          got.ran_id      = m_axis_tdata[15:0];
          got.finished_id = m_axis_tdata[31:16];
          got.done_time   = m_axis_tdata[55:32];
          got.turnaround  = m_axis_tdata[79:56];
          got.waiting     = m_axis_tdata[103:80];
          got.all_done    = m_axis_tdata[104];
          got.wait_total  = m_axis_tdata[136:105];
          got.tat_total   = m_axis_tdata[168:137];
          got.pad         = m_axis_tdata[175:169];
          check_field("load_rejected", want.rejected, got.rejected);
          check_field("ran_valid", want.ran, got.ran);
          check_field("ran_id", want.ran_id, got.ran_id);
          check_field("finished", want.finished, got.finished);
          check_field("finished_id", want.finished_id, got.finished_id);
          check_field("completion_time", want.done_time, got.done_time);
          check_field("turnaround", want.turnaround, got.turnaround);
          check_field("waiting", want.waiting, got.waiting);
          check_field("all_done", want.all_done, got.all_done);
          check_field("total_wait", want.wait_total, got.wait_total);
          check_field("total_turnaround", want.tat_total, got.tat_total);
          check_field("padding", want.pad, got.pad);
        end
        words_seen++;
      end
      waiting_count_o = outcome_q.size();
    end
  end

endmodule

@@ test/tb_srtf_preemptive_scheduler_unit.sv @@
// Testbench top for srtf_preemptive_scheduler_unit: resets the unit, feeds directed and
// random load and tick words under varying back-pressure, and reports the verdict.
// Depends on srtf_pkg, the unit itself and srtf_sched_checker.
module tb_srtf_preemptive_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import srtf_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 79;
  int unsigned words_sent    = 0;
  int unsigned ticks_sent    = 0;
  int unsigned loads_taken   = 0;

  int unsigned mismatch_count;
  int unsigned waiting_count;
  int unsigned finish_count;
  int unsigned reject_count;
  int unsigned idle_tick_count;

  srtf_preemptive_scheduler_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  srtf_sched_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser),
    .mismatch_count_o  (mismatch_count),
    .waiting_count_o   (waiting_count),
    .finish_count_o    (finish_count),
    .reject_count_o    (reject_count),
    .idle_tick_count_o (idle_tick_count)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: drop tready at random.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one word after a random gap and hold it until it is taken.
  task automatic send_word(input logic kind, input logic [15:0] id,
                           input logic [15:0] arr, input logic [15:0] bt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {bt, arr, id};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (kind == MODE_TICK) ticks_sent++;
    else if (bt != 16'd0 && loads_taken < MAX_PROCS) loads_taken++;
  endtask

  // A tick carries random payload, which the unit must ignore.
  task automatic send_tick();
    send_word(MODE_TICK, 16'($urandom()), 16'($urandom()), 16'($urandom()));
  endtask

  // Mostly batches of arriving processes followed by enough ticks to drain them,
  // mixed with refused loads and stray idle ticks.
  task automatic run_random_phase(input int unsigned n_words);
    int unsigned start;
    int unsigned pick;
    int unsigned n_procs;
    int unsigned n_ticks;
    int unsigned off;
    int unsigned k;
    logic [15:0] bt;
    logic [15:0] bt_shared;
    logic [15:0] arr;
    start = words_sent;
    while (words_sent - start < n_words) begin
      pick = $urandom_range(99);
      if (loads_taken >= MAX_PROCS - 3 && loads_taken < MAX_PROCS) begin
        // Last table slots take loads over the whole field range, with a nonzero burst.
        send_word(MODE_LOAD, 16'($urandom()), 16'($urandom()),
                  16'($urandom_range(16'hFFFF, 1)));
      end else if (pick < 8) begin
        // Refused load: zero burst, or any load once the table is full.
        send_word(MODE_LOAD, 16'($urandom()), 16'($urandom()),
                  (loads_taken >= MAX_PROCS) ? 16'($urandom()) : 16'd0);
      end else if (pick < 15) begin
        repeat ($urandom_range(3, 1)) send_tick();
      end else begin
        n_procs   = $urandom_range(3, 1);
        n_ticks   = $urandom_range(3, 0);
        bt_shared = 16'($urandom_range(8, 1));
        for (k = 0; k < n_procs; k++) begin
          bt  = ($urandom_range(2) == 0) ? bt_shared : 16'($urandom_range(12, 1));
          off = $urandom_range(8, 0);
          arr = ($urandom_range(3) == 0 && ticks_sent >= off) ?
                16'(ticks_sent - off) : 16'(ticks_sent + off);
          send_word(MODE_LOAD, 16'($urandom()), arr, bt);
          n_ticks += bt + off;
        end
        repeat (n_ticks) send_tick();
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_LOAD;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: the tick idles and everything counts as done.
    send_tick();
    // A zero burst is refused.
    send_word(MODE_LOAD, 16'h0001, 16'h0000, 16'h0000);
    // Two equal bursts at time zero, the lower slot must win; a shorter one arrives later.
    send_word(MODE_LOAD, 16'hFFFF, 16'h0000, 16'h0002);
    send_word(MODE_LOAD, 16'h0000, 16'h0000, 16'h0002);
    send_word(MODE_LOAD, 16'hA5A5, 16'h0002, 16'h0001);
    // Run all three to completion, then two idle ticks with the table drained.
    repeat (7) send_tick();
    // Late load whose arrival time has passed, then a shorter one, arrival also past, preempts it.
    send_word(MODE_LOAD, 16'h00FF, 16'h0007, 16'h0005);
    send_tick();
    send_word(MODE_LOAD, 16'h0F0F, 16'h0000, 16'h0001);
    repeat (5) send_tick();

    run_random_phase(230);
    send_idle_pct = 79;
    recv_idle_pct = 29;
    run_random_phase(230);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(230);
    s_axis_tvalid <= 1'b0;

    // Drain, then allow one full tick scan for anything stray.
    do @(posedge clk_i); while (waiting_count != 0);
    repeat (80) @(posedge clk_i);

    $display("Sent %0d words: %0d loads entered, %0d refused, %0d ticks (%0d idle).",
             words_sent, loads_taken, reject_count, ticks_sent, idle_tick_count);
    $display("Saw %0d process completions, %0d mismatching fields or words.",
             finish_count, mismatch_count);
    if (mismatch_count == 0 && waiting_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
